>>> design/rbd_pkg.sv
// Shared types, constants and channel expansion functions for the 2x2 box downscaler.
package rbd_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int POS_W      = $clog2(MAX_WIDTH);
   localparam int SIZE_W     = 10;
   localparam int SUM_W      = 9;

   localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] SIZE_DEFAULT = SIZE_W'(466);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } pair_sum_type;

   typedef struct packed {
      logic         valid;
      logic         row_end;
      logic         frame_end;
      pair_sum_type sum;
   } pair_info_type;

   // v*255/31 = 8v + floor(7v/31); the small quotient by reciprocal multiply
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0]  y;
      logic [18:0] p;
      y = ({3'b000, v} << 3) - {3'b000, v};
      p = {11'd0, y} * 19'd2115;
      return {v, 3'b000} + {5'd0, p[18:16]};
   endfunction

   // v*255/63 = 4v + floor(v/21)
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] q;
      if (v >= 6'd63) q = 2'd3;
      else if (v >= 6'd42) q = 2'd2;
      else if (v >= 6'd21) q = 2'd1;
      else q = 2'd0;
      return {v, 2'b00} + {6'd0, q};
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

endpackage

>>> design/rgb565_box_downscale_2x2_unit.sv
// Top level of the RGB565 to RGB888 2x2 box downscaler.
//
// Usage: source pixels enter on the req_ stream in raster order, one per
// cycle while req_tready is high, each as byte-swapped RGB565 in req_tdata;
// req_tuser set marks the first pixel of a frame and resets the position.
// Every 2x2 block yields one averaged RGB888 pixel on the rsp_ stream when
// its bottom-right pixel has been taken; rsp_tlast marks the last pixel of
// an output row and rsp_tuser the last pixel of the frame. Odd last columns
// or rows give no output. Frame size is set over the csr_ port (index 0
// width, index 1 height); the user must set it only while the block is idle,
// as the block itself does not enforce this. csr_ready is always high.
// Throughput: one pixel per cycle while the receiver does not stall. A
// result passes through one input register, one stage holding the line
// store read and one output register. Reset clears the position, the held
// left pixel and all valid bits and restores both sizes to 466; the line
// store needs no clearing pass. When the receiver stalls, the result holds
// and the pipeline keeps taking pixels until its empty stages are filled.
module rgb565_box_downscale_2x2_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,  // [15:0] pixel
   input  logic                           req_tuser,  // [0] frame_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,  // [7:0] red, [15:8] green, [23:16] blue
   output logic                           rsp_tlast,  // row_end
   output logic                           rsp_tuser,  // [0] frame_end
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbd_pkg::SIZE_W-1:0]     csr_data
);

   logic [rbd_pkg::SIZE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [15:0]                pix_ff, pix_in;
   logic                       fs_ff, fs_in, v0_ff, v0_in;
   logic                       s1_ready, s2_ready;
   logic                       mem_wr_en, mem_rd_en;
   logic [rbd_pkg::LINE_AW-1:0] mem_addr;
   rbd_pkg::pair_sum_type      mem_wr_data, mem_rd_data;
   rbd_pkg::pair_info_type     info;
   logic                       out_valid_ff, out_valid_in;
   logic [23:0]                out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in, out_user_ff, out_user_in;
   logic [rbd_pkg::SUM_W:0]    sum_r, sum_g, sum_b;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            rbd_pkg::REG_FRAME_WIDTH:  width_in  = csr_data;
            rbd_pkg::REG_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   // handshake chain: each stage frees when empty or when it moves on
   assign s2_ready   = ~out_valid_ff | rsp_tready;
   assign s1_ready   = ~info.valid | s2_ready;
   assign req_tready = ~v0_ff | s1_ready;

   always_comb begin
      pix_in = pix_ff;
      fs_in  = fs_ff;
      v0_in  = v0_ff;
      if (req_tready) begin
         v0_in  = req_tvalid;
         pix_in = req_tdata;
         fs_in  = req_tuser;
      end
   end

   rbd_pair_stage u_pair (
      .clock        (clock),
      .reset        (reset),
      .s0_valid     (v0_ff),
      .s1_ready     (s1_ready),
      .pixel        (pix_ff),
      .frame_start  (fs_ff),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .mem_wr_en    (mem_wr_en),
      .mem_rd_en    (mem_rd_en),
      .mem_addr     (mem_addr),
      .mem_wr_data  (mem_wr_data),
      .info         (info)
   );

   rbd_line_mem u_line (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   assign sum_r = {1'b0, mem_rd_data.red}   + {1'b0, info.sum.red};
   assign sum_g = {1'b0, mem_rd_data.green} + {1'b0, info.sum.green};
   assign sum_b = {1'b0, mem_rd_data.blue}  + {1'b0, info.sum.blue};

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      if (s2_ready) begin
         out_valid_in = info.valid;
         out_data_in  = {sum_b[rbd_pkg::SUM_W:2], sum_g[rbd_pkg::SUM_W:2],
                         sum_r[rbd_pkg::SUM_W:2]};
         out_last_in  = info.row_end;
         out_user_in  = info.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rbd_pkg::SIZE_DEFAULT;
         height_ff    <= rbd_pkg::SIZE_DEFAULT;
         v0_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         v0_ff        <= v0_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      fs_ff       <= fs_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

>>> design/rbd_line_mem.sv
// Line store of even-row pair sums: one write port, one registered read port.
module rbd_line_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [rbd_pkg::LINE_AW-1:0] wr_addr,
   input  rbd_pkg::pair_sum_type       wr_data,
   input  logic                        rd_en,
   input  logic [rbd_pkg::LINE_AW-1:0] rd_addr,
   output rbd_pkg::pair_sum_type       rd_data
);

   rbd_pkg::pair_sum_type mem [rbd_pkg::LINE_DEPTH];
   rbd_pkg::pair_sum_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rbd_pair_stage.sv
// Position tracking, channel expansion, horizontal pair sums and line store access.
module rbd_pair_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         s0_valid,
   input  logic                         s1_ready,
   input  logic [15:0]                  pixel,
   input  logic                         frame_start,
   input  logic [rbd_pkg::SIZE_W-1:0]   frame_width,
   input  logic [rbd_pkg::SIZE_W-1:0]   frame_height,
   output logic                         mem_wr_en,
   output logic                         mem_rd_en,
   output logic [rbd_pkg::LINE_AW-1:0]  mem_addr,
   output rbd_pkg::pair_sum_type        mem_wr_data,
   output rbd_pkg::pair_info_type       info
);

   logic [rbd_pkg::POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [rbd_pkg::POS_W-1:0]  col, row;
   logic [rbd_pkg::SIZE_W-1:0] w, h, col_next, row_next, last_col, last_row;
   logic [15:0]                swapped;
   rbd_pkg::rgb_type           px_rgb, hold_ff, hold_in;
   rbd_pkg::pair_sum_type      pair;
   rbd_pkg::pair_info_type     info_ff, info_in;
   logic                       move, odd_col, odd_row, row_end;

   assign move = s0_valid & s1_ready;

   assign w = rbd_pkg::clamp_size(frame_width, rbd_pkg::WIDTH_MAX);
   assign h = rbd_pkg::clamp_size(frame_height, rbd_pkg::HEIGHT_MAX);
   assign last_col = {w[rbd_pkg::SIZE_W-1:1], 1'b0} - rbd_pkg::SIZE_W'(1);
   assign last_row = {h[rbd_pkg::SIZE_W-1:1], 1'b0} - rbd_pkg::SIZE_W'(1);

   assign col = frame_start ? '0 : col_ff;
   assign row = frame_start ? '0 : row_ff;
   assign odd_col = col[0];
   assign odd_row = row[0];

   assign swapped = {pixel[7:0], pixel[15:8]};
   assign px_rgb.red   = rbd_pkg::expand5(swapped[15:11]);
   assign px_rgb.green = rbd_pkg::expand6(swapped[10:5]);
   assign px_rgb.blue  = rbd_pkg::expand5(swapped[4:0]);

   assign pair.red   = {1'b0, hold_ff.red}   + {1'b0, px_rgb.red};
   assign pair.green = {1'b0, hold_ff.green} + {1'b0, px_rgb.green};
   assign pair.blue  = {1'b0, hold_ff.blue}  + {1'b0, px_rgb.blue};

   assign row_end = ({1'b0, col} == last_col);

   assign mem_wr_en   = move & odd_col & ~odd_row;
   assign mem_rd_en   = move & odd_col & odd_row;
   assign mem_addr    = col[rbd_pkg::POS_W-1:1];
   assign mem_wr_data = pair;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      hold_in = hold_ff;
      col_next = {1'b0, col} + rbd_pkg::SIZE_W'(1);
      row_next = {1'b0, row} + rbd_pkg::SIZE_W'(1);
      if (move) begin
         if (!odd_col) begin
            hold_in = px_rgb;
         end
         if (col_next >= w) begin
            col_in = '0;
            row_in = (row_next >= h) ? '0 : row_next[rbd_pkg::POS_W-1:0];
         end else begin
            col_in = col_next[rbd_pkg::POS_W-1:0];
            row_in = row;
         end
      end
   end

   always_comb begin
      info_in = info_ff;
      if (s1_ready) begin
         info_in.valid     = mem_rd_en;
         info_in.row_end   = row_end;
         info_in.frame_end = row_end & ({1'b0, row} == last_row);
         info_in.sum       = pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         hold_ff       <= '0;
         info_ff.valid <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         hold_ff       <= hold_in;
         info_ff.valid <= info_in.valid;
      end
      info_ff.row_end   <= info_in.row_end;
      info_ff.frame_end <= info_in.frame_end;
      info_ff.sum       <= info_in.sum;
   end

   assign info = info_ff;

endmodule

>>> sim/box_average_checker.sv
// Checker for the 2x2 box downscaler: predicts each averaged pixel and compares the outputs.
`timescale 1ns / 1ps

module box_average_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // [15:0] pixel
   input  logic                           req_tuser,   // [0] frame_start
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [23:0]                    rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic                           rsp_tlast,   // row_end
   input  logic                           rsp_tuser,   // [0] frame_end
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbd_pkg::SIZE_W-1:0]     csr_data,
   output int                             errors,
   output int                             outstanding
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       frame_end;
   } avg_pixel_type;

   avg_pixel_type              averages_due[$];
   avg_pixel_type              due;
   logic [rbd_pkg::SIZE_W-1:0] width_reg;
   logic [rbd_pkg::SIZE_W-1:0] height_reg;
   logic [26:0]                pair_sums [rbd_pkg::LINE_DEPTH];
   logic [23:0]                left_hold;
   int                         col_pos;
   int                         row_pos;

   function automatic logic [7:0] to_8bit(input int v, input int full_code);
      return 8'(v * 255 / full_code);
   endfunction

   // sizes in use are clamped to [2, max]
   function automatic int clamp_dim(input logic [rbd_pkg::SIZE_W-1:0] v, input int hi);
      if (int'(v) < 2) return 2;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   task automatic take_pixel(input logic [15:0] px, input logic first);
      logic [15:0]   c;
      logic [7:0]    r8, g8, b8;
      logic [8:0]    sr, sg, sb;
      logic [26:0]   above;
      int            w, h, col, row, idx, last_col, last_row;
      avg_pixel_type avg;
      w = clamp_dim(width_reg, rbd_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, rbd_pkg::MAX_HEIGHT);
      c = {px[7:0], px[15:8]};
      r8 = to_8bit(int'(c[15:11]), 31);
      g8 = to_8bit(int'(c[10:5]), 63);
      b8 = to_8bit(int'(c[4:0]), 31);
      if (first) begin
         col_pos = 0;
         row_pos = 0;
      end
      col = col_pos;
      row = row_pos;
      if (col % 2 == 0) begin
         left_hold = {r8, g8, b8};
      end else begin
         sr = 9'(left_hold[23:16]) + 9'(r8);
         sg = 9'(left_hold[15:8]) + 9'(g8);
         sb = 9'(left_hold[7:0]) + 9'(b8);
         idx = col / 2;
         if (row % 2 == 0) begin
            if (idx < rbd_pkg::LINE_DEPTH) pair_sums[idx] = {sr, sg, sb};
         end else begin
            above = (idx < rbd_pkg::LINE_DEPTH) ? pair_sums[idx] : 27'd0;
            last_col = (w & ~1) - 1;
            last_row = (h & ~1) - 1;
            avg.red = 8'((int'(above[26:18]) + int'(sr)) / 4);
            avg.green = 8'((int'(above[17:9]) + int'(sg)) / 4);
            avg.blue = 8'((int'(above[8:0]) + int'(sb)) / 4);
            avg.row_end = (col == last_col);
            avg.frame_end = avg.row_end && (row == last_row);
            averages_due.push_back(avg);
         end
      end
      col++;
      // wraps also when a smaller size was set mid-frame
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_pos = col;
      row_pos = row;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = rbd_pkg::SIZE_DEFAULT;
         height_reg = rbd_pkg::SIZE_DEFAULT;
         left_hold = '0;
         col_pos = 0;
         row_pos = 0;
         averages_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rbd_pkg::REG_FRAME_WIDTH: width_reg = csr_data;
               rbd_pkg::REG_FRAME_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (averages_due.size() == 0) begin
               $error("result with nothing due: rgb %h row_end %b frame_end %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               errors++;
            end else begin
               due = averages_due.pop_front();
               if (rsp_tdata[7:0] !== due.red) begin
                  $error("red: expected %0d, got %0d", due.red, rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tdata[15:8] !== due.green) begin
                  $error("green: expected %0d, got %0d", due.green, rsp_tdata[15:8]);
                  errors++;
               end
               if (rsp_tdata[23:16] !== due.blue) begin
                  $error("blue: expected %0d, got %0d", due.blue, rsp_tdata[23:16]);
                  errors++;
               end
               if (rsp_tlast !== due.row_end) begin
                  $error("row_end: expected %0d, got %0d", due.row_end, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser !== due.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", due.frame_end, rsp_tuser);
                  errors++;
               end
            end
         end
      end
      outstanding = averages_due.size();
   end

endmodule

>>> sim/testbench.sv
// Top of the 2x2 box downscaler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [15:0]                   req_tdata = '0;   // [15:0] pixel
   logic                          req_tuser = 1'b0; // [0] frame_start
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [23:0]                   rsp_tdata;        // [7:0] red, [15:8] green, [23:16] blue
   logic                          rsp_tlast;        // row_end
   logic                          rsp_tuser;        // [0] frame_end
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [rbd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rbd_pkg::SIZE_W-1:0]    csr_data = '0;

   int errors;
   int outstanding;
   int idle_pct = 0;
   int stall_pct = 0;
   int cur_width = 466;
   int cur_height = 466;

   // 4x4 frame of extremes and single-channel maxima, then a 3x3 frame
   localparam logic [15:0] EDGE_PIXELS [0:24] = '{
      16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
      16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
      16'h00F8, 16'hE007, 16'h1F00, 16'hFFFF,
      16'hE007, 16'h1F00, 16'h00F8, 16'h0000,
      16'h1F00, 16'h00F8, 16'hE007,
      16'hFFFF, 16'h0000, 16'hFFFF,
      16'h1234, 16'h5678, 16'h9ABC
   };

   rgb565_box_downscale_2x2_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   box_average_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_pixel(input logic [15:0] px, input logic first);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [rbd_pkg::CSR_IDX_W-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= rbd_pkg::SIZE_W'(value);
      if (index == rbd_pkg::REG_FRAME_WIDTH) cur_width = value;
      else cur_height = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // drain all due results, then let a pixel that causes none leave the pipeline
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic int pick_size();
      case ($urandom_range(0, 15))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 512;
         4: return 513;
         5: return 1023;
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   initial begin
      int random_items;
      int phase;
      int count;
      int ew, eh;
      int cycles;
      logic fresh;
      logic first;
      logic [15:0] px;
      random_items = 0;
      phase = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // one even row at full width writes every line entry, so later reads are safe
      write_reg(rbd_pkg::REG_FRAME_WIDTH, 512);
      write_reg(rbd_pkg::REG_FRAME_HEIGHT, 2);
      for (int i = 0; i < 512; i++) send_pixel(16'($urandom_range(0, 65535)), i == 0);
      settle();

      idle_pct = 35;
      stall_pct = 35;
      write_reg(rbd_pkg::REG_FRAME_WIDTH, 4);
      write_reg(rbd_pkg::REG_FRAME_HEIGHT, 4);
      for (int i = 0; i < 16; i++) send_pixel(EDGE_PIXELS[i], i == 0);
      settle();
      // odd size: last column and last row give nothing
      write_reg(rbd_pkg::REG_FRAME_WIDTH, 3);
      write_reg(rbd_pkg::REG_FRAME_HEIGHT, 3);
      for (int i = 16; i < 25; i++) send_pixel(EDGE_PIXELS[i], i == 16);
      settle();

      while (random_items < 380) begin
         case (phase % 5)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            3: begin idle_pct = 35; stall_pct = 35; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         if ($urandom_range(0, 3) != 0) write_reg(rbd_pkg::REG_FRAME_WIDTH, pick_size());
         if ($urandom_range(0, 3) != 0) write_reg(rbd_pkg::REG_FRAME_HEIGHT, pick_size());
         // now and then keep the position, so the new size applies mid-frame
         fresh = ($urandom_range(0, 4) != 0);
         ew = (cur_width < 2) ? 2 :
              (cur_width > rbd_pkg::MAX_WIDTH) ? rbd_pkg::MAX_WIDTH : cur_width;
         eh = (cur_height < 2) ? 2 :
              (cur_height > rbd_pkg::MAX_HEIGHT) ? rbd_pkg::MAX_HEIGHT : cur_height;
         count = $urandom_range(16, 64);
         for (int k = 0; k < count; k++) begin
            first = (fresh && (k % (ew * eh) == 0)) || ($urandom_range(0, 31) == 0);
            case ($urandom_range(0, 7))
               0: px = 16'h0000;
               1: px = 16'hFFFF;
               default: px = 16'($urandom_range(0, 65535));
            endcase
            send_pixel(px, first);
            random_items++;
         end
         settle();
         phase++;
      end

      req_tvalid <= 1'b0;
      cycles = 0;
      while (outstanding != 0 && cycles < 100000) begin
         @(negedge clock);
         cycles++;
      end
      if (outstanding == 0) repeat (16) @(negedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
